>>> sv/sha_pkg.sv
package sha_pkg;

    // One byte handed from the front to the back
    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } sha_byte_t;

    typedef enum logic [2:0] {
        F_ACCEPT = 3'b001,
        F_ZERO   = 3'b010,
        F_LEN    = 3'b100
    } sha_front_state_t;

    typedef enum logic [3:0] {
        B_LOAD  = 4'b0001,
        B_ROUND = 4'b0010,
        B_ADD   = 4'b0100,
        B_OUT   = 4'b1000
    } sha_back_state_t;

    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_FINISH = 1'b1;
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_KEY [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

>>> sv/sha_stream_if.sv
interface sha_msg_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, digest_word, word_index, last, input ready);
    modport sink (input valid, digest_word, word_index, last, output ready);
endinterface

>>> sv/sha_front.sv
module sha_front
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sha_msg_if.sink   msg,
    output logic      byte_valid,
    input  logic      byte_ready,
    output sha_byte_t byte_out
);

    sha_front_state_t state_reg, state_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] len_sr_reg, len_sr_next;
    logic [5:0]  pos_reg, pos_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        push;

    assign msg.ready = (state_reg == F_ACCEPT) && byte_ready;
    assign push      = byte_valid && byte_ready;

    // Select the byte to hand on: message data, pad marker, zero fill or length
    always_comb
    begin
        byte_valid     = 1'b0;
        byte_out.value = 8'h00;
        byte_out.fin   = 1'b0;
        case (state_reg)
            F_ACCEPT:
            begin
                byte_valid     = msg.valid;
                byte_out.value = (msg.kind == KIND_DATA) ? msg.data_byte : PAD_BYTE;
            end
            F_ZERO:
            begin
                byte_valid = 1'b1;
            end
            F_LEN:
            begin
                byte_valid     = 1'b1;
                byte_out.value = len_sr_reg[63:56];
                byte_out.fin   = (cnt_reg == 3'd7);
            end
            default:
            begin
                byte_valid = 1'b0;
            end
        endcase
    end

    // Advance the position, length and padding sequence
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        len_sr_next = len_sr_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            pos_next = pos_reg + 6'd1;
            case (state_reg)
                F_ACCEPT:
                begin
                    if (msg.kind == KIND_DATA)
                    begin
                        len_next = len_reg + 64'd8;
                    end
                    else
                    begin
                        len_sr_next = len_reg;
                        cnt_next    = 3'd0;
                        state_next  = (pos_next == LEN_POS) ? F_LEN : F_ZERO;
                    end
                end
                F_ZERO:
                begin
                    if (pos_next == LEN_POS)
                    begin
                        state_next = F_LEN;
                    end
                end
                F_LEN:
                begin
                    len_sr_next = {len_sr_reg[55:0], 8'h00};
                    cnt_next    = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        len_next   = 64'd0;
                        state_next = F_ACCEPT;
                    end
                end
                default:
                begin
                    state_next = F_ACCEPT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_ACCEPT;
            len_reg   <= 64'd0;
            pos_reg   <= 6'd0;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_sr_reg <= len_sr_next;
    end

endmodule

>>> sv/sha_queue.sv
module sha_queue
    import sha_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  sha_byte_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output sha_byte_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sha_byte_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Hold entries until the back takes them
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> sv/sha_back.sv
module sha_back
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  sha_byte_t   byte_in,
    sha_digest_if.source digest
);

    sha_back_state_t state_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] var_reg [8];
    logic [31:0] win_reg [16];
    logic [23:0] acc_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        fin_reg;
    logic        take;
    logic [31:0] w_new, t1, t2, s0w, s1w, bs0, bs1, ch, maj;

    assign byte_ready = (state_reg == B_LOAD);
    assign take       = byte_valid && byte_ready;

    // Round logic: schedule word and the two temporaries
    always_comb
    begin
        s0w = {win_reg[1][6:0], win_reg[1][31:7]} ^ {win_reg[1][17:0], win_reg[1][31:18]}
            ^ (win_reg[1] >> 3);
        s1w = {win_reg[14][16:0], win_reg[14][31:17]} ^ {win_reg[14][18:0], win_reg[14][31:19]}
            ^ (win_reg[14] >> 10);
        w_new = s1w + win_reg[9] + s0w + win_reg[0];
        bs1 = {var_reg[4][5:0], var_reg[4][31:6]} ^ {var_reg[4][10:0], var_reg[4][31:11]}
            ^ {var_reg[4][24:0], var_reg[4][31:25]};
        bs0 = {var_reg[0][1:0], var_reg[0][31:2]} ^ {var_reg[0][12:0], var_reg[0][31:13]}
            ^ {var_reg[0][21:0], var_reg[0][31:22]};
        ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^ (var_reg[1] & var_reg[2]);
        t1  = var_reg[7] + bs1 + ch + ROUND_KEY[round_reg] + win_reg[0];
        t2  = bs0 + maj;
    end

    assign digest.valid       = (state_reg == B_OUT);
    assign digest.digest_word = hash_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last        = (idx_reg == 3'd7);

    // Schedule window: shift in packed words, then roll during rounds
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            acc_reg <= {acc_reg[15:0], byte_in.value};
            if (pos_reg[1:0] == 2'd3)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[15] <= {acc_reg, byte_in.value};
            end
        end
        else if (state_reg == B_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
    end

    // Sequence loading, rounds, final add and digest transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_LOAD;
            pos_reg   <= 6'd0;
            round_reg <= 6'd0;
            idx_reg   <= 3'd0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= IV[i];
                var_reg[i]  <= 32'd0;
            end
        end
        else
        begin
            case (state_reg)
                B_LOAD:
                begin
                    if (take)
                    begin
                        pos_reg <= pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                        begin
                            fin_reg   <= byte_in.fin;
                            round_reg <= 6'd0;
                            state_reg <= B_ROUND;
                            for (int i = 0; i < 8; i++)
                            begin
                                var_reg[i] <= hash_reg[i];
                            end
                        end
                    end
                end
                B_ROUND:
                begin
                    var_reg[7] <= var_reg[6];
                    var_reg[6] <= var_reg[5];
                    var_reg[5] <= var_reg[4];
                    var_reg[4] <= var_reg[3] + t1;
                    var_reg[3] <= var_reg[2];
                    var_reg[2] <= var_reg[1];
                    var_reg[1] <= var_reg[0];
                    var_reg[0] <= t1 + t2;
                    round_reg  <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= B_ADD;
                    end
                end
                B_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + var_reg[i];
                    end
                    idx_reg   <= 3'd0;
                    state_reg <= fin_reg ? B_OUT : B_LOAD;
                end
                B_OUT:
                begin
                    if (digest.ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                hash_reg[i] <= IV[i];
                            end
                            state_reg <= B_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_add_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ADD && fin_reg) |=> (state_reg == B_OUT))
        else $error("final block did not lead to digest output");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ROUND && round_reg == 6'd63) |=> (state_reg == B_ADD))
        else $error("round 63 not followed by hash add");
    a_last_back: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.last) |=>
        (state_reg == B_LOAD && hash_reg[0] == IV[0]))
        else $error("hash not restored after last digest word");
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LOAD && $past(state_reg) == B_ADD) |-> (pos_reg == 6'd0))
        else $error("byte position not aligned after compression");
`endif

endmodule

>>> sv/sha256_message_hasher_core.sv
// Channel   Modport  Payload
// msg       sink     kind, data_byte
// digest    source   digest_word, word_index, last
//
// A data byte is taken while the front is accepting and the byte queue has room; each 64-byte
// block is then loaded, run through the rounds and added into the hash in the back.
// A finish transaction is expanded by the front into 9 to 72 pad and length bytes, one per
// cycle while the queue has room, followed by eight digest transactions from the back.
// Asynchronous active-low reset restores the initial hash and empties the byte queue.
// The queue between front and back lets the front take bytes during compression until full.
module sha256_message_hasher_core
    import sha_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    sha_msg_if.sink      msg,
    sha_digest_if.source digest
);

    sha_byte_t f_byte, b_byte;
    logic      f_valid, f_ready, b_valid, b_ready;

    sha_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .byte_valid (f_valid),
        .byte_ready (f_ready),
        .byte_out   (f_byte)
    );

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_byte),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_byte)
    );

    sha_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (b_valid),
        .byte_ready (b_ready),
        .byte_in    (b_byte),
        .digest     (digest)
    );

endmodule

>>> tb/sha_tb_if.sv
`timescale 1ns / 100ps

// Testbench copies of the channel interfaces are provided by the RTL files;
// this file holds the scoreboard used by the top module.
package sha_tb_pkg;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } digest_t;

    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    class digest_scoreboard;
        logic [31:0] hash [8];
        logic [31:0] sched [16];
        logic [63:0] msg_bits;
        logic [5:0]  pos;
        digest_t     pending [$];
        int          errors;

        function new();
            hash     = H0;
            msg_bits = '0;
            pos      = '0;
            errors   = 0;
        endfunction

        function void compress();
            logic [31:0] v [8];
            logic [31:0] w, t1, t2, s0, s1;
            v = hash;
            for (int t = 0; t < 64; t++)
            begin
                if (t < 16)
                    w = sched[t];
                else
                begin
                    s0 = sched[(t - 15) & 15];
                    s1 = sched[(t - 2) & 15];
                    w  = (rotr(s1, 17) ^ rotr(s1, 19) ^ (s1 >> 10)) + sched[(t - 7) & 15]
                       + (rotr(s0, 7) ^ rotr(s0, 18) ^ (s0 >> 3)) + sched[t & 15];
                    sched[t & 15] = w;
                end
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w;
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hash[i] += v[i];
        endfunction

        function void append(logic [7:0] b);
            int sh;
            sh = (3 - pos[1:0]) * 8;
            if (pos[1:0] == 0)
                sched[pos[5:2]] = 32'(b) << sh;
            else
                sched[pos[5:2]] |= 32'(b) << sh;
            pos++;
            if (pos == 0)
                compress();
        endfunction

        // Note an accepted input transaction and predict any digest words
        function void note_input(logic kind, logic [7:0] b);
            logic [63:0] len;
            digest_t     d;
            if (kind == 1'b0)
            begin
                append(b);
                msg_bits += 64'd8;
                return;
            end
            len = msg_bits;
            append(8'h80);
            while (pos != 6'd56)
                append(8'h00);
            for (int i = 0; i < 8; i++)
                append(len[63 - 8 * i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash[i];
                d.word_index  = 3'(i);
                d.last        = (i == 7);
                pending.push_back(d);
            end
            hash     = H0;
            msg_bits = '0;
            pos      = '0;
        endfunction

        // Compare an accepted digest transaction with the oldest prediction
        function void check_digest(digest_t got);
            digest_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected digest transaction %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("digest mismatch: expected word %h idx %0d last %0d, got %h %0d %0d",
                             want.digest_word, want.word_index, want.last,
                             got.digest_word, got.word_index, got.last);
            end
        endfunction
    endclass

endpackage

>>> tb/tb_sha256_message_hasher_core.sv
`timescale 1ns / 100ps

module tb_sha256_message_hasher_core;
    import sha_pkg::*;
    import sha_tb_pkg::*;

    logic clk;
    logic rst_n;
    int   cycles;
    int   hold_off;
    bit   no_idle;

    sha_msg_if    msg ();
    sha_digest_if digest ();

    digest_scoreboard board;

    sha256_message_hasher_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .digest (digest)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles and stop on a runaway simulation
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("tb_sha256_message_hasher_core NOT OK");
            $finish;
        end
    end

    // Sink side: random stalls plus a long hold-off set by the test
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digest.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off     <= hold_off - 1;
            digest.ready <= 1'b0;
        end
        else
            digest.ready <= no_idle || ($urandom_range(99) >= 16);
    end

    // Check every accepted digest transaction
    always @(posedge clk)
    begin
        if (rst_n && digest.valid && digest.ready)
            board.check_digest({digest.digest_word, digest.word_index, digest.last});
    end

    // Offer one transaction and hold it until accepted; valid stays up for the next one
    task automatic send(logic kind, logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 16)
        begin
            msg.valid <= 1'b0;
            @(posedge clk);
        end
        msg.valid     <= 1'b1;
        msg.kind      <= kind;
        msg.data_byte <= b;
        do
            @(posedge clk);
        while (!msg.ready);
        board.note_input(kind, b);
    endtask

    task automatic send_message(int n, int pattern);
        for (int i = 0; i < n; i++)
            case (pattern)
                0:       send(KIND_DATA, 8'h00);
                1:       send(KIND_DATA, 8'hff);
                default: send(KIND_DATA, 8'($urandom));
            endcase
        send(KIND_FINISH, 8'($urandom));
    endtask

    task automatic drain();
        msg.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board         = new();
        cycles        = 0;
        hold_off      = 0;
        no_idle       = 1'b0;
        msg.valid     = 1'b0;
        msg.kind      = KIND_DATA;
        msg.data_byte = 8'h00;
        rst_n         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, byte extremes, block boundary lengths
        send(KIND_FINISH, 8'hff);
        send_message(1, 0);
        send_message(1, 1);
        send_message(3, 2);
        send_message(55, 2);
        drain();
        send_message(56, 1);
        send_message(64, 0);

        // Pause until every digest has come, then stall the sink hard
        drain();
        hold_off = 300;
        send_message(20, 2);
        send_message(2, 2);

        // Run without idling for a stretch
        no_idle = 1'b1;
        send_message(30, 2);
        no_idle = 1'b0;

        // Random short messages
        repeat (14) send_message($urandom_range(8), 2);

        drain();
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_sha256_message_hasher_core OK");
        else
            $display("tb_sha256_message_hasher_core NOT OK");
        $finish;
    end

endmodule

>>> sim.f
sv/sha_pkg.sv
sv/sha_stream_if.sv
sv/sha_front.sv
sv/sha_queue.sv
sv/sha_back.sv
sv/sha256_message_hasher_core.sv
tb/sha_tb_if.sv
tb/tb_sha256_message_hasher_core.sv
